// ----- rtl/core/isp_pkg.sv -----
// isp_pkg: shared types and constants of the incremental shortest path engine
// holds command codes, the classified command type and the back-end state enum
// no dependencies
package isp_pkg;

    localparam int CMD_W        = 3;
    localparam int NODE_ID_W    = 10;
    localparam int WEIGHT_MAX_W = 16;
    localparam int DIST_W       = 18;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELAX  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_REMOVE,
        OP_START,
        OP_RELAX,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [NODE_ID_W-1:0]    from_node;
        logic [NODE_ID_W-1:0]    to_node;
        logic [WEIGHT_MAX_W-1:0] edge_weight;
    } t_item;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FIND_RD,
        S_FIND_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_MARK_RD,
        S_MARK_WR,
        S_RND,
        S_U_RD,
        S_U_CHK,
        S_U_NEXT,
        S_E_RD,
        S_E_CHK,
        S_V_CHK
    } t_state;

endpackage

// ----- rtl/core/isp_front.sv -----
// isp_front: accepts command beats, classifies them and queues them
// two-entry queue toward the back end; depends on isp_pkg
module isp_front #(
    parameter int NODE_COUNT  = 1024,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [isp_pkg::CMD_W-1:0]        i_cmd,
    input  logic [isp_pkg::NODE_ID_W-1:0]    i_from_node,
    input  logic [isp_pkg::NODE_ID_W-1:0]    i_to_node,
    input  logic [WEIGHT_BITS-1:0]           i_edge_weight,
    output isp_pkg::t_item                   o_item,
    output logic                             o_valid,
    input  logic                             i_pop
);

    logic           r_wp, r_rp;
    logic [1:0]     r_cnt, n_cnt;
    isp_pkg::t_item r_q [2];
    isp_pkg::t_item cls;
    logic           push;
    logic           from_bad, to_bad;

    assign busy    = (r_cnt == 2'd2);
    assign push    = start && !busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    assign from_bad = (32'(i_from_node) >= NODE_COUNT);
    assign to_bad   = (32'(i_to_node) >= NODE_COUNT);

    always_comb begin
        cls.from_node   = i_from_node;
        cls.to_node     = i_to_node;
        cls.edge_weight = isp_pkg::WEIGHT_MAX_W'(i_edge_weight);
        unique case (i_cmd)
            isp_pkg::CMD_ADD:    cls.op = isp_pkg::OP_ADD;
            isp_pkg::CMD_REMOVE: cls.op = isp_pkg::OP_REMOVE;
            isp_pkg::CMD_START:  cls.op = isp_pkg::OP_START;
            isp_pkg::CMD_RELAX:  cls.op = isp_pkg::OP_RELAX;
            isp_pkg::CMD_READ:   cls.op = isp_pkg::OP_READ;
            default:             cls.op = isp_pkg::OP_NOP;
        endcase
        // an out of range from node, or an out of range to node on an add or remove, turns the beat into a no-op
        if (from_bad || ((cls.op == isp_pkg::OP_ADD || cls.op == isp_pkg::OP_REMOVE)
                         && to_bad)) begin
            cls.op = isp_pkg::OP_NOP;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop && o_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

// ----- rtl/core/isp_back.sv -----
// isp_back: executes classified commands against the edge and node memories
// edits, start sweep, round-based relaxation and reads; depends on isp_pkg
module isp_back #(
    parameter int NODE_COUNT  = 1024,
    parameter int EDGE_COUNT  = 4096,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  isp_pkg::t_item                i_item,
    input  logic                          i_valid,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic                          o_status,
    output logic [isp_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_reachable,
    output logic [isp_pkg::NODE_ID_W-1:0] o_parent_node,
    output logic                          o_has_parent
);

    localparam int NB  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int EIW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
    localparam int ECW = $clog2(EDGE_COUNT + 1);
    localparam int DW  = isp_pkg::DIST_W;

    typedef struct packed {
        logic [DW-1:0] cost;
        logic          reach;
        logic          pval;
        logic [NB-1:0] par;
        logic          m0;
        logic          m1;
    } t_nword;

    typedef struct packed {
        logic [NB-1:0]          src;
        logic [NB-1:0]          dst;
        logic [WEIGHT_BITS-1:0] wt;
    } t_eword;

    t_nword r_nmem [NODE_COUNT];
    t_eword r_emem [EDGE_COUNT];
    t_nword r_nd;
    t_eword r_ed;

    logic            nd_re, nd_we, ed_re, ed_we;
    logic [NB-1:0]   nd_raddr, nd_waddr;
    logic [EIW-1:0]  ed_raddr, ed_waddr;
    t_nword          nd_wdata;
    t_eword          ed_wdata;

    isp_pkg::t_state r_state, n_state;
    logic            r_par, n_par, r_start, n_start, r_changed, n_changed;
    logic [ECW-1:0]  r_ecnt, n_ecnt, r_k, n_k, k_inc;
    logic [NB-1:0]   r_u, n_u, r_f, n_f, r_t, n_t, r_v, n_v;
    logic [WEIGHT_BITS-1:0] r_w, n_w, r_wt, n_wt;
    logic [DW-1:0]   r_du, n_du;
    logic [DW:0]     cand_sum;
    logic [DW-1:0]   cand;
    logic            cur_bit;
    logic            r_is_add, n_is_add;
    t_nword          tmp;

    logic                          r_o_valid, n_o_valid, r_o_status, n_o_status;
    logic [DW-1:0]                 r_o_dist, n_o_dist;
    logic                          r_o_reach, n_o_reach, r_o_hpar, n_o_hpar;
    logic [isp_pkg::NODE_ID_W-1:0] r_o_par, n_o_par;

    assign o_strobe      = r_o_valid;
    assign o_status      = r_o_status;
    assign o_distance    = r_o_dist;
    assign o_reachable   = r_o_reach;
    assign o_parent_node = r_o_par;
    assign o_has_parent  = r_o_hpar;

    assign k_inc    = r_k + ECW'(1);
    assign cur_bit  = r_par ? r_nd.m1 : r_nd.m0;
    assign cand_sum = {1'b0, r_du} + (DW+1)'(r_wt);
    assign cand     = cand_sum[DW] ? isp_pkg::DIST_INF : cand_sum[DW-1:0];

    always_comb begin
        n_state    = r_state;
        n_par      = r_par;
        n_start    = r_start;
        n_changed  = r_changed;
        n_ecnt     = r_ecnt;
        n_k        = r_k;
        n_u        = r_u;
        n_f        = r_f;
        n_t        = r_t;
        n_v        = r_v;
        n_w        = r_w;
        n_wt       = r_wt;
        n_du       = r_du;
        n_is_add   = r_is_add;
        o_pop      = 1'b0;
        nd_re      = 1'b0;
        nd_raddr   = r_u;
        nd_we      = 1'b0;
        nd_waddr   = r_u;
        nd_wdata   = r_nd;
        ed_re      = 1'b0;
        ed_raddr   = r_k[EIW-1:0];
        ed_we      = 1'b0;
        ed_waddr   = r_k[EIW-1:0];
        ed_wdata   = r_ed;
        tmp        = r_nd;
        n_o_valid  = 1'b0;
        n_o_status = 1'b0;
        n_o_dist   = '0;
        n_o_reach  = 1'b0;
        n_o_par    = '0;
        n_o_hpar   = 1'b0;

        unique case (r_state)
            // streaming sweep: write node u while node u+1 is read
            isp_pkg::S_CLEAR: begin
                nd_we    = 1'b1;
                nd_re    = 1'b1;
                nd_raddr = r_u + NB'(1);
                tmp      = '0;
                tmp.cost = isp_pkg::DIST_INF;
                // a start keeps the marks left by earlier edits
                if (r_start) begin
                    tmp.m0 = r_nd.m0;
                    tmp.m1 = r_nd.m1;
                    if (r_u == r_f) begin
                        tmp.cost  = '0;
                        tmp.reach = 1'b1;
                        if (r_par) tmp.m1 = 1'b1;
                        else       tmp.m0 = 1'b1;
                    end
                end
                nd_wdata = tmp;
                if (r_u == NB'(NODE_COUNT - 1)) begin
                    n_u     = '0;
                    n_start = 1'b0;
                    n_state = r_start ? isp_pkg::S_RND : isp_pkg::S_IDLE;
                end else begin
                    n_u = r_u + NB'(1);
                end
            end
            isp_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_pop    = 1'b1;
                    n_f      = NB'(i_item.from_node);
                    n_t      = NB'(i_item.to_node);
                    n_w      = WEIGHT_BITS'(i_item.edge_weight);
                    n_is_add = (i_item.op == isp_pkg::OP_ADD);
                    n_k      = '0;
                    unique case (i_item.op)
                        isp_pkg::OP_READ: begin
                            nd_re    = 1'b1;
                            nd_raddr = NB'(i_item.from_node);
                            n_state  = isp_pkg::S_READ;
                        end
                        isp_pkg::OP_ADD, isp_pkg::OP_REMOVE: n_state = isp_pkg::S_FIND_RD;
                        isp_pkg::OP_START: begin
                            nd_re    = 1'b1;
                            nd_raddr = '0;
                            n_u      = '0;
                            n_start  = 1'b1;
                            n_state  = isp_pkg::S_CLEAR;
                        end
                        isp_pkg::OP_RELAX: n_state = isp_pkg::S_RND;
                        default: n_o_valid = 1'b1;
                    endcase
                end
            end
            isp_pkg::S_READ: begin
                n_o_valid = 1'b1;
                if (r_nd.reach) begin
                    n_o_dist  = r_nd.cost;
                    n_o_reach = 1'b1;
                end
                if (r_nd.pval) begin
                    n_o_par  = isp_pkg::NODE_ID_W'(r_nd.par);
                    n_o_hpar = 1'b1;
                end
                n_state = isp_pkg::S_IDLE;
            end
            isp_pkg::S_FIND_RD: begin
                if (r_k == r_ecnt) begin
                    if (r_is_add && r_ecnt == ECW'(EDGE_COUNT)) begin
                        n_o_valid  = 1'b1;
                        n_o_status = 1'b1;
                        n_state    = isp_pkg::S_IDLE;
                    end else begin
                        n_state = r_is_add ? isp_pkg::S_APPEND : isp_pkg::S_MARK_RD;
                    end
                end else begin
                    ed_re   = 1'b1;
                    n_state = isp_pkg::S_FIND_CHK;
                end
            end
            isp_pkg::S_FIND_CHK: begin
                if (r_ed.src == r_f && r_ed.dst == r_t) begin
                    n_state = isp_pkg::S_SHIFT_RD;
                end else begin
                    n_k     = k_inc;
                    n_state = isp_pkg::S_FIND_RD;
                end
            end
            // compact the table: move every younger entry down one slot
            isp_pkg::S_SHIFT_RD: begin
                if (k_inc == r_ecnt) begin
                    n_ecnt  = r_ecnt - ECW'(1);
                    n_state = r_is_add ? isp_pkg::S_APPEND : isp_pkg::S_MARK_RD;
                end else begin
                    ed_re    = 1'b1;
                    ed_raddr = k_inc[EIW-1:0];
                    n_state  = isp_pkg::S_SHIFT_WR;
                end
            end
            isp_pkg::S_SHIFT_WR: begin
                ed_we   = 1'b1;
                n_k     = k_inc;
                n_state = isp_pkg::S_SHIFT_RD;
            end
            isp_pkg::S_APPEND: begin
                ed_we        = 1'b1;
                ed_waddr     = r_ecnt[EIW-1:0];
                ed_wdata.src = r_f;
                ed_wdata.dst = r_t;
                ed_wdata.wt  = r_w;
                n_ecnt       = r_ecnt + ECW'(1);
                n_state      = isp_pkg::S_MARK_RD;
            end
            isp_pkg::S_MARK_RD: begin
                nd_re    = 1'b1;
                nd_raddr = r_f;
                n_state  = isp_pkg::S_MARK_WR;
            end
            isp_pkg::S_MARK_WR: begin
                if (r_nd.reach) begin
                    nd_we    = 1'b1;
                    nd_waddr = r_f;
                    if (r_par) tmp.m1 = 1'b1;
                    else       tmp.m0 = 1'b1;
                    nd_wdata = tmp;
                end
                n_o_valid = 1'b1;
                n_state   = isp_pkg::S_IDLE;
            end
            isp_pkg::S_RND: begin
                n_changed = 1'b0;
                n_u       = '0;
                n_state   = isp_pkg::S_U_RD;
            end
            isp_pkg::S_U_RD: begin
                nd_re   = 1'b1;
                n_state = isp_pkg::S_U_CHK;
            end
            // consume the affected bit of this round, then walk edges newest first
            isp_pkg::S_U_CHK: begin
                n_state = isp_pkg::S_U_NEXT;
                if (cur_bit) begin
                    nd_we = 1'b1;
                    if (r_par) tmp.m1 = 1'b0;
                    else       tmp.m0 = 1'b0;
                    nd_wdata = tmp;
                    if (r_nd.reach) begin
                        n_du    = r_nd.cost;
                        n_k     = r_ecnt;
                        n_state = isp_pkg::S_E_RD;
                    end
                end
            end
            isp_pkg::S_U_NEXT: begin
                if (r_u == NB'(NODE_COUNT - 1)) begin
                    if (r_changed) begin
                        n_par   = !r_par;
                        n_state = isp_pkg::S_RND;
                    end else begin
                        n_o_valid = 1'b1;
                        n_state   = isp_pkg::S_IDLE;
                    end
                end else begin
                    n_u     = r_u + NB'(1);
                    n_state = isp_pkg::S_U_RD;
                end
            end
            isp_pkg::S_E_RD: begin
                if (r_k == '0) begin
                    n_state = isp_pkg::S_U_NEXT;
                end else begin
                    ed_re    = 1'b1;
                    ed_raddr = EIW'(r_k - ECW'(1));
                    n_k      = r_k - ECW'(1);
                    n_state  = isp_pkg::S_E_CHK;
                end
            end
            isp_pkg::S_E_CHK: begin
                if (r_ed.src == r_u) begin
                    nd_re    = 1'b1;
                    nd_raddr = r_ed.dst;
                    n_v      = r_ed.dst;
                    n_wt     = r_ed.wt;
                    n_state  = isp_pkg::S_V_CHK;
                end else begin
                    n_state = isp_pkg::S_E_RD;
                end
            end
            isp_pkg::S_V_CHK: begin
                if (!r_nd.reach || cand < r_nd.cost) begin
                    nd_we     = 1'b1;
                    nd_waddr  = r_v;
                    tmp.cost  = cand;
                    tmp.reach = 1'b1;
                    tmp.pval  = 1'b1;
                    tmp.par   = r_u;
                    if (r_par) tmp.m0 = 1'b1;
                    else       tmp.m1 = 1'b1;
                    nd_wdata  = tmp;
                    n_changed = 1'b1;
                end
                n_state = isp_pkg::S_E_RD;
            end
            default: n_state = isp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= isp_pkg::S_CLEAR;
            r_par     <= 1'b0;
            r_start   <= 1'b0;
            r_changed <= 1'b0;
            r_ecnt    <= '0;
            r_u       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_par     <= n_par;
            r_start   <= n_start;
            r_changed <= n_changed;
            r_ecnt    <= n_ecnt;
            r_u       <= n_u;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_f        <= n_f;
        r_t        <= n_t;
        r_v        <= n_v;
        r_w        <= n_w;
        r_wt       <= n_wt;
        r_du       <= n_du;
        r_is_add   <= n_is_add;
        r_o_status <= n_o_status;
        r_o_dist   <= n_o_dist;
        r_o_reach  <= n_o_reach;
        r_o_par    <= n_o_par;
        r_o_hpar   <= n_o_hpar;
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) r_nmem[nd_waddr] <= nd_wdata;
        if (nd_re) r_nd <= r_nmem[nd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ed_we) r_emem[ed_waddr] <= ed_wdata;
        if (ed_re) r_ed <= r_emem[ed_raddr];
    end

    a_ecnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= ECW'(EDGE_COUNT))
        else $error("edge count above table size");

    a_ecnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ecnt != $past(r_ecnt)) |->
        (r_ecnt == $past(r_ecnt) + ECW'(1) || r_ecnt == $past(r_ecnt) - ECW'(1)))
        else $error("edge count moved by more than one");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> (!o_reachable && !o_has_parent && o_distance == '0))
        else $error("rejected add carries node data");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != isp_pkg::S_IDLE || o_strobe))
        else $error("pop without a command in progress");

endmodule

// ----- rtl/core/incremental_shortest_path_engine_unit.sv -----
// incremental_shortest_path_engine_unit: top level of the shortest path engine
// front end classifier/queue plus back end executor; depends on isp_pkg,
// isp_front and isp_back
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------------
//  command   | start / busy          | i_cmd, i_from_node, i_to_node, i_edge_weight
//  result    | o_strobe (one cycle)  | o_status, o_distance, o_reachable,
//            |                       | o_parent_node, o_has_parent
//
// every command beat gives one result beat; an edit scans the stored edges and
// moves the entries behind a matched edge down; a relax walks every node per
// round and the stored edges of each affected reachable node; a start adds a
// sweep of the node memory before relaxing. after reset a clearing sweep of the
// node memory runs; beats queue (two deep) meanwhile. the result side cannot
// stall, busy only covers a full queue
module incremental_shortest_path_engine_unit #(
    parameter int NODE_COUNT  = 1024,
    parameter int EDGE_COUNT  = 4096,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [isp_pkg::CMD_W-1:0]     i_cmd,
    input  logic [isp_pkg::NODE_ID_W-1:0] i_from_node,
    input  logic [isp_pkg::NODE_ID_W-1:0] i_to_node,
    input  logic [WEIGHT_BITS-1:0]        i_edge_weight,
    output logic                          o_strobe,
    output logic                          o_status,
    output logic [isp_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_reachable,
    output logic [isp_pkg::NODE_ID_W-1:0] o_parent_node,
    output logic                          o_has_parent
);

    isp_pkg::t_item item;
    logic           item_valid;
    logic           item_pop;

    isp_front #(
        .NODE_COUNT (NODE_COUNT),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_from_node  (i_from_node),
        .i_to_node    (i_to_node),
        .i_edge_weight(i_edge_weight),
        .o_item       (item),
        .o_valid      (item_valid),
        .i_pop        (item_pop)
    );

    isp_back #(
        .NODE_COUNT (NODE_COUNT),
        .EDGE_COUNT (EDGE_COUNT),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_valid      (item_valid),
        .o_pop        (item_pop),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_distance   (o_distance),
        .o_reachable  (o_reachable),
        .o_parent_node(o_parent_node),
        .o_has_parent (o_has_parent)
    );

endmodule

// ----- tb/incremental_shortest_path_engine_unit_test.sv -----
// testbench for incremental_shortest_path_engine_unit: directed table then random
// command beats, checked against an in-bench shortest path predictor or, for
// mk_zero rows, an all-zero answer; depends on isp_pkg and the rtl top level
`timescale 1ns / 1ps

module incremental_shortest_path_engine_unit_test;

    localparam int NODES     = 1024;
    localparam int LINKS_MAX = 4096;
    localparam int N_RANDOM  = 1430;
    localparam int WATCH_MAX = 2000000;

    typedef struct {
        logic [isp_pkg::NODE_ID_W-1:0] src;
        logic [isp_pkg::NODE_ID_W-1:0] dst;
        logic [7:0]                    wt;
    } link_t;

    typedef struct {
        logic                          status;
        logic [isp_pkg::DIST_W-1:0]    cost;
        logic                          reach;
        logic [isp_pkg::NODE_ID_W-1:0] par;
        logic                          has_par;
    } answer_t;

    typedef struct {
        logic [isp_pkg::CMD_W-1:0]     cmd;
        logic [isp_pkg::NODE_ID_W-1:0] from_n;
        logic [isp_pkg::NODE_ID_W-1:0] to_n;
        logic [7:0]                    wt;
        bit                            typed;
        answer_t                       ans;
    } row_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [isp_pkg::CMD_W-1:0]     i_cmd = '0;
    logic [isp_pkg::NODE_ID_W-1:0] i_from_node = '0;
    logic [isp_pkg::NODE_ID_W-1:0] i_to_node = '0;
    logic [7:0]                    i_edge_weight = '0;
    logic                          o_strobe;
    logic                          o_status;
    logic [isp_pkg::DIST_W-1:0]    o_distance;
    logic                          o_reachable;
    logic [isp_pkg::NODE_ID_W-1:0] o_parent_node;
    logic                          o_has_parent;

    incremental_shortest_path_engine_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_from_node   (i_from_node),
        .i_to_node     (i_to_node),
        .i_edge_weight (i_edge_weight),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_distance    (o_distance),
        .o_reachable   (o_reachable),
        .o_parent_node (o_parent_node),
        .o_has_parent  (o_has_parent)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    link_t                      links[$];
    logic [isp_pkg::DIST_W-1:0] dist_of[NODES];
    bit [NODES-1:0]             reach_of;
    bit [NODES-1:0]             has_par_of;
    logic [9:0]                 par_of[NODES];
    bit [NODES-1:0]             affected;

    answer_t pending_answers[$];
    int      fail_count = 0;
    int      idle_watch = 0;
    int      idle_pct   = 10;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic relax_paths();
        bit [NODES-1:0] next_round;
        bit             changed;
        logic [isp_pkg::DIST_W:0] cand;
        int v;
        do begin
            changed = 0;
            next_round = '0;
            for (int u = 0; u < NODES; u++) begin
                if (!affected[u] || !reach_of[u]) continue;
                // newest edges first
                for (int i = links.size() - 1; i >= 0; i--) begin
                    if (links[i].src != u) continue;
                    cand = dist_of[u] + links[i].wt;
                    if (cand > isp_pkg::DIST_INF) cand = isp_pkg::DIST_INF;
                    v = links[i].dst;
                    if (!reach_of[v] || cand < dist_of[v]) begin
                        dist_of[v]    = cand[isp_pkg::DIST_W-1:0];
                        reach_of[v]   = 1;
                        par_of[v]     = 10'(u);
                        has_par_of[v] = 1;
                        next_round[v] = 1;
                        changed       = 1;
                    end
                end
            end
            affected = next_round;
        end while (changed);
        affected = '0;
    endtask

    function automatic int find_link(input int s, input int d);
        for (int i = 0; i < links.size(); i++)
            if (links[i].src == s && links[i].dst == d) return i;
        return -1;
    endfunction

    task automatic predict_answer(input logic [isp_pkg::CMD_W-1:0] cmd, input int f,
                                  input int t, input logic [7:0] w, output answer_t a);
        int at;
        link_t l;
        a = '{default: '0};
        case (cmd)
            isp_pkg::CMD_ADD: begin
                at = find_link(f, t);
                if (at >= 0) links.delete(at);
                else if (links.size() >= LINKS_MAX) begin
                    a.status = 1;
                    return;
                end
                l.src = isp_pkg::NODE_ID_W'(f);
                l.dst = isp_pkg::NODE_ID_W'(t);
                l.wt  = w;
                links.push_back(l);
                if (reach_of[f]) affected[f] = 1;
            end
            isp_pkg::CMD_REMOVE: begin
                at = find_link(f, t);
                if (at >= 0) links.delete(at);
                if (reach_of[f]) affected[f] = 1;
            end
            isp_pkg::CMD_START: begin
                for (int n = 0; n < NODES; n++) dist_of[n] = isp_pkg::DIST_INF;
                reach_of = '0;
                has_par_of = '0;
                dist_of[f] = 0;
                reach_of[f] = 1;
                affected[f] = 1;
                relax_paths();
            end
            isp_pkg::CMD_RELAX: relax_paths();
            isp_pkg::CMD_READ: begin
                if (reach_of[f]) begin
                    a.cost  = dist_of[f];
                    a.reach = 1;
                end
                if (has_par_of[f]) begin
                    a.par     = par_of[f];
                    a.has_par = 1;
                end
            end
            default: ;
        endcase
    endtask

    // send one beat; start stays high across back-to-back beats
    task automatic send_beat(input row_t r);
        answer_t a;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= r.cmd;
        i_from_node   <= r.from_n;
        i_to_node     <= r.to_n;
        i_edge_weight <= r.wt;
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        predict_answer(r.cmd, r.from_n, r.to_n, r.wt, a);
        pending_answers.push_back(r.typed ? r.ans : a);
        idle_watch = 0;
    endtask

    // result beats cannot be held off, sample mid-cycle
    always @(negedge i_clk) begin
        answer_t e;
        if (i_rst_n && o_strobe) begin
            idle_watch = 0;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                e = pending_answers.pop_front();
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                if (o_distance !== e.cost) report_mismatch("distance", o_distance, e.cost);
                if (o_reachable !== e.reach)
                    report_mismatch("reachable", o_reachable, e.reach);
                if (o_parent_node !== e.par)
                    report_mismatch("parent_node", o_parent_node, e.par);
                if (o_has_parent !== e.has_par)
                    report_mismatch("has_parent", o_has_parent, e.has_par);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_watch++;
            if (idle_watch >= WATCH_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic row_t mk(input logic [isp_pkg::CMD_W-1:0] c, input int f,
                                input int t, input int w);
        row_t r;
        r = '{default: '0};
        r.cmd    = c;
        r.from_n = isp_pkg::NODE_ID_W'(f);
        r.to_n   = isp_pkg::NODE_ID_W'(t);
        r.wt     = 8'(w);
        return r;
    endfunction

    function automatic row_t mk_zero(input logic [isp_pkg::CMD_W-1:0] c, input int f,
                                     input int t, input int w);
        row_t r;
        r = mk(c, f, t, w);
        r.typed = 1;
        return r;
    endfunction

    function automatic int pick_node();
        if ($urandom_range(99) < 8) return $urandom_range(NODES - 1);
        return $urandom_range(15);
    endfunction

    row_t table_rows[$];
    row_t r;
    int   roll;

    initial begin
        for (int n = 0; n < NODES; n++) begin
            dist_of[n] = isp_pkg::DIST_INF;
            par_of[n]  = '0;
        end
        reach_of = '0; has_par_of = '0; affected = '0;

        // directed table
        table_rows.push_back(mk_zero(isp_pkg::CMD_READ, 0, 0, 0)); // nothing reachable yet
        table_rows.push_back(mk_zero(isp_pkg::CMD_READ, 1023, 0, 0));
        table_rows.push_back(mk_zero(3'd5, 1023, 1023, 255));      // unused codes
        table_rows.push_back(mk_zero(3'd6, 0, 0, 0));
        table_rows.push_back(mk_zero(3'd7, 512, 341, 170));
        table_rows.push_back(mk_zero(isp_pkg::CMD_ADD, 0, 1023, 255));
        table_rows.push_back(mk_zero(isp_pkg::CMD_ADD, 1023, 512, 0));
        table_rows.push_back(mk_zero(isp_pkg::CMD_ADD, 0, 682, 85));
        table_rows.push_back(mk_zero(isp_pkg::CMD_ADD, 0, 1023, 3)); // replaces the first edge
        table_rows.push_back(mk_zero(isp_pkg::CMD_START, 0, 0, 0));
        table_rows.push_back(mk(isp_pkg::CMD_READ, 0, 0, 0));
        table_rows.push_back(mk(isp_pkg::CMD_READ, 1023, 0, 0));
        table_rows.push_back(mk(isp_pkg::CMD_READ, 512, 0, 0));
        table_rows.push_back(mk(isp_pkg::CMD_READ, 682, 0, 0));
        table_rows.push_back(mk_zero(isp_pkg::CMD_REMOVE, 5, 6, 0)); // missing edge
        table_rows.push_back(mk_zero(isp_pkg::CMD_REMOVE, 0, 682, 0));
        table_rows.push_back(mk_zero(isp_pkg::CMD_ADD, 682, 1023, 1));
        table_rows.push_back(mk_zero(isp_pkg::CMD_ADD, 0, 682, 0));
        table_rows.push_back(mk_zero(isp_pkg::CMD_RELAX, 0, 0, 0));
        table_rows.push_back(mk(isp_pkg::CMD_READ, 1023, 0, 0));
        table_rows.push_back(mk(isp_pkg::CMD_READ, 512, 0, 0));
        table_rows.push_back(mk(isp_pkg::CMD_READ, 341, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) send_beat(table_rows[i]);

        for (int k = 0; k < N_RANDOM; k++) begin
            idle_pct = (k < N_RANDOM / 3) ? 10 : (k < 2 * N_RANDOM / 3) ? 56 : 0;
            roll = $urandom_range(99);
            if (links.size() > 48 && roll < 40) roll = 45;
            if (roll < 40)
                r = mk(isp_pkg::CMD_ADD, pick_node(), pick_node(), $urandom_range(255));
            else if (roll < 55)
                r = mk(isp_pkg::CMD_REMOVE, pick_node(), pick_node(), $urandom_range(255));
            else if (roll < 57)
                r = mk(isp_pkg::CMD_START, pick_node(), $urandom_range(1023), 0);
            else if (roll < 59)
                r = mk(isp_pkg::CMD_RELAX, $urandom_range(1023), $urandom_range(1023), 0);
            else if (roll < 61)
                r = mk(3'($urandom_range(5, 7)), $urandom_range(1023),
                       $urandom_range(1023), $urandom_range(255));
            else
                r = mk(isp_pkg::CMD_READ, pick_node(), $urandom_range(1023), 0);
            // removes mostly hit a stored edge
            if (r.cmd == isp_pkg::CMD_REMOVE && links.size() > 0 && $urandom_range(3) != 0) begin
                roll = $urandom_range(links.size() - 1);
                r.from_n = links[roll].src;
                r.to_n   = links[roll].dst;
            end
            send_beat(r);
        end
        start <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/isp_pkg.sv
rtl/core/isp_front.sv
rtl/core/isp_back.sv
rtl/core/incremental_shortest_path_engine_unit.sv
tb/incremental_shortest_path_engine_unit_test.sv
